### rtl/cbs_pkg.sv
// cbs_pkg: shared types, constants and helpers of the centered binomial sampler
// used by cbs_front, cbs_queue, cbs_back and centered_binomial_sampler
package cbs_pkg;

   localparam int POLY_LENGTH = 256;
   localparam int CNT_W       = $clog2(POLY_LENGTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int ETA_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int COEFF_W   = 4;
   localparam int INDEX_W   = 8;

   localparam logic [ETA_W-1:0] ETA_RESET = 3'd2;
   localparam logic [ETA_W-1:0] ETA_TWO   = 3'd2;
   localparam logic [ETA_W-1:0] ETA_THREE = 3'd3;

   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(POLY_LENGTH - 1);

   typedef enum logic [1:0] {
      ETA_SEL_2,
      ETA_SEL_3,
      ETA_SEL_4
   } eta_sel_type;

   // one sampled coefficient as it leaves the block
   typedef struct packed {
      logic signed [COEFF_W-1:0] coefficient;
      logic [INDEX_W-1:0]        coeff_index;
      logic                      end_of_poly;
   } coeff_type;

   // everything one input byte produces: one or two coefficients
   typedef struct packed {
      logic      two;
      coeff_type first;
      coeff_type second;
   } record_type;

   function automatic logic [2:0] ones4(input logic [3:0] v);
      ones4 = 3'({2'b0, v[0]} + {2'b0, v[1]} + {2'b0, v[2]} + {2'b0, v[3]});
   endfunction

   // difference of two popcounts, both halves zero padded to four bits
   function automatic logic signed [COEFF_W-1:0] cbd(input logic [3:0] lo,
                                                     input logic [3:0] hi);
      cbd = signed'(COEFF_W'({1'b0, ones4(lo)}) - COEFF_W'({1'b0, ones4(hi)}));
   endfunction

   function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] c);
      logic [CNT_W+INDEX_W-1:0] w;
      w = {{INDEX_W{1'b0}}, c};
      to_index = w[INDEX_W-1:0];
   endfunction

endpackage

### rtl/centered_binomial_sampler.sv
// centered_binomial_sampler: top level, front stage, record queue, back stage
// depends on cbs_pkg, cbs_front, cbs_queue, cbs_back
//
// Random bytes go in through push/full, one per cycle while full is low; each
// byte yields one or two signed coefficients (eta 2: two, eta 4: one, eta 3:
// one or two with bits carried between bytes) that come out through empty/pop
// one per transfer. The front stage does all of a byte's work in its cycle of
// entry; a four-record queue lets input and output stall on their own. The
// output port moves one coefficient per cycle while pop is high, so sustained
// input of one byte per cycle holds only for eta 4, as eta 2 and 3 bytes can
// yield two. A result is queued when its byte is taken and leaves after older ones.
// Write eta through csr_valid/csr_ready only while no results are pending.
module centered_binomial_sampler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [cbs_pkg::BYTE_W-1:0]         req_rand_byte,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [cbs_pkg::COEFF_W-1:0] rsp_coefficient,
   output logic [cbs_pkg::INDEX_W-1:0]        rsp_coeff_index,
   output logic                               rsp_end_of_poly,
   output logic                               rsp_last_in_run,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cbs_pkg::ETA_W-1:0]          csr_eta
);
   import cbs_pkg::*;

   record_type new_record;
   record_type head_record;
   logic       accept;
   logic       head_empty;
   logic       head_pop;

   assign accept = push && !full;

   cbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rand_byte (req_rand_byte),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_eta   (csr_eta),
      .record    (new_record)
   );

   cbs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (new_record),
      .full    (full),
      .rd_en   (head_pop),
      .rd_data (head_record),
      .empty   (head_empty)
   );

   cbs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head_record),
      .head_empty      (head_empty),
      .head_pop        (head_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_coefficient (rsp_coefficient),
      .rsp_coeff_index (rsp_coeff_index),
      .rsp_end_of_poly (rsp_end_of_poly),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule

### rtl/cbs_front.sv
// cbs_front: takes random bytes, keeps the carried bits and the coefficient
// counter, and builds one record per byte; depends on cbs_pkg
module cbs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [cbs_pkg::BYTE_W-1:0]  rand_byte,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cbs_pkg::ETA_W-1:0]   csr_eta,
   output cbs_pkg::record_type         record
);
   import cbs_pkg::*;

   logic [ETA_W-1:0] eta_ff, eta_in;
   logic [3:0]       carry_bits_ff, carry_bits_in;
   logic [2:0]       carry_count_ff, carry_count_in;
   logic [CNT_W-1:0] coeff_count_ff, coeff_count_in;

   eta_sel_type      eta_sel;
   logic [3:0]       cb_eff;
   logic [2:0]       cc_eff;
   logic [11:0]      stream;
   logic [CNT_W-1:0] count_plus1;
   logic             end0, end1;
   logic             two_raw;

   assign csr_ready = 1'b1;

   always_comb begin
      eta_in = eta_ff;
      if (csr_valid) begin
         eta_in = csr_eta;
      end
   end

   always_comb begin
      if (eta_ff <= ETA_TWO) begin
         eta_sel = ETA_SEL_2;
      end else if (eta_ff == ETA_THREE) begin
         eta_sel = ETA_SEL_3;
      end else begin
         eta_sel = ETA_SEL_4;
      end
   end

   always_comb begin
      cb_eff = (eta_sel == ETA_SEL_3) ? carry_bits_ff : 4'd0;
      cc_eff = (eta_sel == ETA_SEL_3) ? carry_count_ff : 3'd0;
      stream = {8'd0, cb_eff} | ({4'd0, rand_byte} << cc_eff);
      count_plus1 = coeff_count_ff + 1'b1;
      end0 = (coeff_count_ff == LAST_POS);
      end1 = (count_plus1 == LAST_POS);

      record = '0;
      two_raw = 1'b0;
      case (eta_sel)
         ETA_SEL_2: begin
            two_raw = 1'b1;
            record.first.coefficient  = cbd({2'b0, stream[1:0]}, {2'b0, stream[3:2]});
            record.second.coefficient = cbd({2'b0, stream[5:4]}, {2'b0, stream[7:6]});
         end
         ETA_SEL_3: begin
            two_raw = (cc_eff == 3'd4);
            record.first.coefficient  = cbd({1'b0, stream[2:0]}, {1'b0, stream[5:3]});
            record.second.coefficient = cbd({1'b0, stream[8:6]}, {1'b0, stream[11:9]});
         end
         default: begin
            two_raw = 1'b0;
            record.first.coefficient  = cbd(stream[3:0], stream[7:4]);
         end
      endcase
      // a polynomial ending on the first coefficient drops the rest of the byte
      record.two = two_raw && !end0;
      record.first.coeff_index  = to_index(coeff_count_ff);
      record.first.end_of_poly  = end0;
      record.second.coeff_index = to_index(count_plus1);
      record.second.end_of_poly = end1;
   end

   always_comb begin
      coeff_count_in = coeff_count_ff;
      carry_bits_in  = carry_bits_ff;
      carry_count_in = carry_count_ff;
      if (accept) begin
         if (end0) begin
            coeff_count_in = '0;
            carry_bits_in  = 4'd0;
            carry_count_in = 3'd0;
         end else if (two_raw) begin
            coeff_count_in = end1 ? '0 : CNT_W'(coeff_count_ff + 2'd2);
            carry_bits_in  = 4'd0;
            carry_count_in = 3'd0;
         end else if (eta_sel == ETA_SEL_3) begin
            coeff_count_in = count_plus1;
            carry_bits_in  = stream[9:6];
            carry_count_in = 3'(cc_eff + 3'd2);
         end else begin
            coeff_count_in = count_plus1;
            carry_bits_in  = 4'd0;
            carry_count_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff         <= ETA_RESET;
         carry_bits_ff  <= 4'd0;
         carry_count_ff <= 3'd0;
         coeff_count_ff <= '0;
      end else begin
         eta_ff         <= eta_in;
         carry_bits_ff  <= carry_bits_in;
         carry_count_ff <= carry_count_in;
         coeff_count_ff <= coeff_count_in;
      end
   end

endmodule

### rtl/cbs_queue.sv
// cbs_queue: short queue of per-byte records between front and back
// depends on cbs_pkg
module cbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  cbs_pkg::record_type wr_data,
   output logic                full,
   input  logic                rd_en,
   output cbs_pkg::record_type rd_data,
   output logic                empty
);
   import cbs_pkg::*;

   record_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              do_wr, do_rd;

   assign full    = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      do_wr = wr_en && !full;
      do_rd = rd_en && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/cbs_back.sv
// cbs_back: hands out the coefficients of the head record one per transfer
// depends on cbs_pkg
module cbs_back (
   input  logic                               clock,
   input  logic                               reset,
   input  cbs_pkg::record_type                head,
   input  logic                               head_empty,
   output logic                               head_pop,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [cbs_pkg::COEFF_W-1:0] rsp_coefficient,
   output logic [cbs_pkg::INDEX_W-1:0]        rsp_coeff_index,
   output logic                               rsp_end_of_poly,
   output logic                               rsp_last_in_run
);
   import cbs_pkg::*;

   logic      second_ff, second_in;
   coeff_type sel;
   logic      take;

   assign empty = head_empty;
   assign take  = pop && !head_empty;

   always_comb begin
      sel = second_ff ? head.second : head.first;
      rsp_coefficient = sel.coefficient;
      rsp_coeff_index = sel.coeff_index;
      rsp_end_of_poly = sel.end_of_poly;
      rsp_last_in_run = second_ff || !head.two;
      head_pop  = 1'b0;
      second_in = second_ff;
      if (take) begin
         if (head.two && !second_ff) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            head_pop  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

### dv/centered_binomial_sampler_tb.sv
// centered_binomial_sampler_tb: self-checking bench for the centered binomial sampler
// drives random bytes through push/full, checks coefficients at empty/pop
// depends on cbs_pkg and centered_binomial_sampler
`timescale 1ns / 100ps

module centered_binomial_sampler_tb;
   import cbs_pkg::*;

   localparam int               CYCLE_LIMIT  = 200000;
   localparam int               RANDOM_BYTES = 430;
   localparam int               DRAIN_CYCLES = 8;
   localparam logic [ETA_W-1:0] ETA_FOUR     = 3'd4;

   typedef struct {
      logic signed [COEFF_W-1:0] coefficient;
      logic [INDEX_W-1:0]        coeff_index;
      logic                      end_of_poly;
      logic                      last_in_run;
   } sample_type;

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      full;
   logic [BYTE_W-1:0]         req_rand_byte;
   logic                      empty;
   logic                      pop;
   logic signed [COEFF_W-1:0] rsp_coefficient;
   logic [INDEX_W-1:0]        rsp_coeff_index;
   logic                      rsp_end_of_poly;
   logic                      rsp_last_in_run;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [ETA_W-1:0]          csr_eta;

   // sampler state as the bench sees it
   logic [ETA_W-1:0] model_eta;
   logic [3:0]       leftover_bits;
   int               leftover_count;
   int               poly_pos;

   sample_type pending_coeffs[$];
   int      error_count;
   int      cycle_count;
   int      burst_left;
   logic [15:0] pop_pattern;
   logic [3:0]  pop_phase;

   centered_binomial_sampler i_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_rand_byte   (req_rand_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_coefficient (rsp_coefficient),
      .rsp_coeff_index (rsp_coeff_index),
      .rsp_end_of_poly (rsp_end_of_poly),
      .rsp_last_in_run (rsp_last_in_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_eta         (csr_eta)
   );

   always #5 clock = ~clock;

   // expected coefficients for one accepted byte
   task automatic predict_coefficients(input logic [BYTE_W-1:0] rand_byte);
      int         eff_eta;
      int         avail;
      int         n;
      int         ones_lo;
      int         ones_hi;
      logic [11:0] stream;
      sample_type batch[2];
      begin
         eff_eta = (model_eta < ETA_TWO) ? 2 : (model_eta > ETA_FOUR) ? 4 : int'(model_eta);
         if (eff_eta != 3) begin
            leftover_bits  = '0;
            leftover_count = 0;
         end
         stream = 12'(leftover_bits) | (12'(rand_byte) << leftover_count);
         avail  = leftover_count + 8;
         n      = 0;
         while (avail >= 2 * eff_eta && n < 2) begin
            ones_lo = 0;
            ones_hi = 0;
            for (int k = 0; k < eff_eta; k++) begin
               ones_lo += stream[k];
               ones_hi += stream[eff_eta + k];
            end
            batch[n].coefficient = COEFF_W'(ones_lo - ones_hi);
            batch[n].coeff_index = INDEX_W'(poly_pos);
            batch[n].end_of_poly = (poly_pos >= POLY_LENGTH - 1);
            batch[n].last_in_run = 1'b0;
            stream = stream >> (2 * eff_eta);
            avail  = avail - 2 * eff_eta;
            n++;
            if (batch[n-1].end_of_poly) begin
               // rest of the byte is thrown away at a polynomial boundary
               poly_pos = 0;
               avail    = 0;
               stream   = '0;
               break;
            end
            poly_pos++;
         end
         if (eff_eta == 3 && avail <= 4) begin
            leftover_bits  = 4'(stream & ((12'd1 << avail) - 12'd1));
            leftover_count = avail;
         end else begin
            leftover_bits  = '0;
            leftover_count = 0;
         end
         batch[n-1].last_in_run = 1'b1;
         for (int k = 0; k < n; k++)
            pending_coeffs.push_back(batch[k]);
      end
   endtask

   // one byte transfer, with bursts and random gaps on the push side
   task automatic send_byte(input logic [BYTE_W-1:0] rand_byte);
      int gap;
      begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
         end
         req_rand_byte <= rand_byte;
         push          <= 1'b1;
         do @(posedge clock); while (full);
         predict_coefficients(rand_byte);
         burst_left--;
      end
   endtask

   task automatic stop_sending();
      begin
         push       <= 1'b0;
         burst_left = 0;
      end
   endtask

   task automatic wait_idle();
      begin
         while (pending_coeffs.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   task automatic write_eta(input logic [ETA_W-1:0] value);
      begin
         stop_sending();
         wait_idle();
         csr_eta   <= value;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         model_eta = value;
         csr_valid <= 1'b0;
      end
   endtask

   task automatic test_default_eta();
      begin
         send_byte(8'h00);
         send_byte(8'hFF);
         send_byte(8'h0F);
         send_byte(8'hF0);
         send_byte(8'h33);
         send_byte(8'hCC);
      end
   endtask

   task automatic test_eta_three_four();
      begin
         write_eta(ETA_THREE);
         send_byte(8'h07);
         send_byte(8'hFF);
         send_byte(8'h00);
         send_byte(8'hAA);
         write_eta(ETA_FOUR);
         send_byte(8'h0F);
         send_byte(8'hF0);
         send_byte(8'hFF);
         send_byte(8'h00);
      end
   endtask

   // out-of-range values clamp to 2 or 4
   task automatic test_eta_clamp();
      logic [ETA_W-1:0] odd_values[5];
      begin
         odd_values = '{3'd0, 3'd1, 3'd5, 3'd6, 3'd7};
         foreach (odd_values[k]) begin
            write_eta(odd_values[k]);
            send_byte(8'($urandom));
         end
      end
   endtask

   // leftover bits from eta 3 must be dropped when eta changes
   task automatic test_carry_drop();
      begin
         write_eta(ETA_THREE);
         send_byte(8'hC0);
         write_eta(ETA_TWO);
         send_byte(8'h5A);
         write_eta(ETA_THREE);
         send_byte(8'hFF);
         send_byte(8'hFF);
         write_eta(ETA_FOUR);
         send_byte(8'h3C);
      end
   endtask

   task automatic test_random_stream();
      int               sent;
      int               phase_len;
      logic [ETA_W-1:0] eta_pick;
      begin
         sent = 0;
         while (sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 5))
               0, 1:    eta_pick = ETA_THREE;
               2:       eta_pick = ETA_TWO;
               3:       eta_pick = ETA_FOUR;
               default: eta_pick = ETA_W'($urandom_range(0, 7));
            endcase
            write_eta(eta_pick);
            phase_len = $urandom_range(10, 70);
            if (phase_len > RANDOM_BYTES - sent) begin
               phase_len = RANDOM_BYTES - sent;
            end
            repeat (phase_len) send_byte(8'($urandom));
            sent += phase_len;
         end
         stop_sending();
      end
   endtask

   // result side: check each transfer, then pick the next pop from the stall pattern
   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         pop         <= 1'b0;
         pop_pattern <= 16'hFFFF;
         pop_phase   <= 4'd0;
      end else begin
         if (pop && !empty) begin
            if (pending_coeffs.size() == 0) begin
               $error("unexpected coefficient %0d at index %0d",
                      rsp_coefficient, rsp_coeff_index);
               error_count++;
            end else begin
               want = pending_coeffs.pop_front();
               if (rsp_coefficient !== want.coefficient) begin
                  $error("coefficient: expected %0d, got %0d",
                         want.coefficient, rsp_coefficient);
                  error_count++;
               end
               if (rsp_coeff_index !== want.coeff_index) begin
                  $error("coeff_index: expected %0d, got %0d",
                         want.coeff_index, rsp_coeff_index);
                  error_count++;
               end
               if (rsp_end_of_poly !== want.end_of_poly) begin
                  $error("end_of_poly: expected %0b, got %0b",
                         want.end_of_poly, rsp_end_of_poly);
                  error_count++;
               end
               if (rsp_last_in_run !== want.last_in_run) begin
                  $error("last_in_run: expected %0b, got %0b",
                         want.last_in_run, rsp_last_in_run);
                  error_count++;
               end
            end
         end
         pop <= pop_pattern[pop_phase];
         if (pop_phase == 4'd15) begin
            pop_phase <= 4'd0;
            case ($urandom_range(0, 3))
               0:       pop_pattern <= 16'hFFFF;
               1:       pop_pattern <= 16'($urandom);
               2:       pop_pattern <= 16'($urandom) & 16'($urandom);
               default: pop_pattern <= 16'($urandom) | 16'($urandom);
            endcase
         end else begin
            pop_phase <= pop_phase + 4'd1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("centered_binomial_sampler_tb: done, errors");
      $finish;
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      push           = 1'b0;
      req_rand_byte  = '0;
      csr_valid      = 1'b0;
      csr_eta        = ETA_RESET;
      model_eta      = ETA_RESET;
      leftover_bits  = '0;
      leftover_count = 0;
      poly_pos       = 0;
      error_count    = 0;
      burst_left     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_eta();
      test_eta_three_four();
      test_eta_clamp();
      test_carry_drop();
      test_random_stream();

      wait_idle();
      if (pending_coeffs.size() != 0) begin
         $error("%0d coefficients never arrived", pending_coeffs.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("centered_binomial_sampler_tb: done, clean");
      end else begin
         $display("centered_binomial_sampler_tb: done, errors");
      end
      $finish;
   end

endmodule
